// File: design/pptzc_pkg.sv
// Package for the pulse peak, trough and zero-crossing finder: widths, codes, reset values.
`timescale 1ns / 1ps
`default_nettype none
package pptzc_pkg;

  localparam int TICK_BITS_DEF   = 13;
  localparam int SAMPLE_BITS_DEF = 16;

  // Configuration register widths
  localparam int MODE_BITS  = 2;
  localparam int PRE_BITS   = 10;
  localparam int TOTAL_BITS = 11;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 11;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_ALIGN_MODE    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PRE_SAMPLES   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_TOTAL_SAMPLES = 2'd2;

  // Alignment modes
  localparam logic [MODE_BITS-1:0] MODE_NONE = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_PEAK = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_ZERO = 2'd2;

  // Register reset values
  localparam logic [MODE_BITS-1:0]  ALIGN_MODE_RST    = MODE_PEAK;
  localparam logic [PRE_BITS-1:0]   PRE_SAMPLES_RST   = 10'd0;
  localparam logic [TOTAL_BITS-1:0] TOTAL_SAMPLES_RST = 11'd64;

endpackage
`default_nettype wire

// File: design/pptzc_in_if.sv
// Sample channel: valid/ready handshake with one sample of a region per transaction.
`timescale 1ns / 1ps
`default_nettype none
interface pptzc_in_if #(
  parameter int TICK_BITS   = pptzc_pkg::TICK_BITS_DEF,
  parameter int SAMPLE_BITS = pptzc_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_value;
  logic        [TICK_BITS-1:0]   tick;
  logic                          first_in_roi;
  logic                          last_in_roi;

  modport source (output valid, sample_value, tick, first_in_roi, last_in_roi, input ready);
  modport sink   (input valid, sample_value, tick, first_in_roi, last_in_roi, output ready);
endinterface
`default_nettype wire

// File: design/pptzc_out_if.sv
// Result channel: valid/ready handshake with one region summary per transaction.
`timescale 1ns / 1ps
`default_nettype none
interface pptzc_out_if #(
  parameter int TICK_BITS = pptzc_pkg::TICK_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [TICK_BITS-1:0] roi_begin;
  logic [TICK_BITS:0]   roi_end;
  logic [TICK_BITS-1:0] peak_tick;
  logic [TICK_BITS-1:0] trough_tick;
  logic [TICK_BITS-1:0] zero_cross_tick;
  logic                 align_ok;
  logic [TICK_BITS-1:0] window_begin;
  logic [TICK_BITS:0]   window_end;

  modport source (output valid, roi_begin, roi_end, peak_tick, trough_tick, zero_cross_tick,
                  align_ok, window_begin, window_end, input ready);
  modport sink   (input valid, roi_begin, roi_end, peak_tick, trough_tick, zero_cross_tick,
                  align_ok, window_begin, window_end, output ready);
endinterface
`default_nettype wire

// File: design/pptzc_cfg_if.sv
// Configuration write channel: valid/ready handshake carrying a register index and data.
`timescale 1ns / 1ps
`default_nettype none
interface pptzc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [pptzc_pkg::CFG_IDX_BITS-1:0]  reg_index;
  logic [pptzc_pkg::CFG_DATA_BITS-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface
`default_nettype wire

// File: design/pulse_peak_trough_zero_crossing.sv
// Top level of the bipolar pulse peak, trough and zero-crossing finder.
// A region's result is registered and appears in the cycle after its last sample is accepted.
// Throughput: one sample per cycle; the running compares and the crop window
// arithmetic sit between the tracking registers and the result register.
// Samples keep flowing while a result waits, as long as the result register drains.
// Reset (rst_n low, synchronous): clears tracking state and the result valid,
// and loads align_mode 1, pre_samples 0, total_samples 64.
`timescale 1ns / 1ps
`default_nettype none
module pulse_peak_trough_zero_crossing #(
  parameter int TICK_BITS   = pptzc_pkg::TICK_BITS_DEF,
  parameter int SAMPLE_BITS = pptzc_pkg::SAMPLE_BITS_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  pptzc_in_if.sink     in_if,
  pptzc_out_if.source  out_if,
  pptzc_cfg_if.sink    cfg_if
);
  import pptzc_pkg::*;

  // Width for the anchor minus pre_samples compare, and for the window end sum
  localparam int CW = (TICK_BITS > PRE_BITS) ? TICK_BITS : PRE_BITS;
  localparam int SW = (TICK_BITS + 1 > TOTAL_BITS) ? TICK_BITS + 1 : TOTAL_BITS;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes must land only while the block is idle;
  // the block itself does not enforce this, and the port is always ready.
  // ---------------------------------------------------------------------------
  logic [MODE_BITS-1:0]  align_mode_r;
  logic [PRE_BITS-1:0]   pre_samples_r;
  logic [TOTAL_BITS-1:0] total_samples_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      align_mode_r    <= ALIGN_MODE_RST;
      pre_samples_r   <= PRE_SAMPLES_RST;
      total_samples_r <= TOTAL_SAMPLES_RST;
    end else if (cfg_if.valid) begin
      case (cfg_if.reg_index)
        REG_ALIGN_MODE:    align_mode_r    <= cfg_if.wdata[MODE_BITS-1:0];
        REG_PRE_SAMPLES:   pre_samples_r   <= cfg_if.wdata[PRE_BITS-1:0];
        REG_TOTAL_SAMPLES: total_samples_r <= cfg_if.wdata[TOTAL_BITS-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake. A sample is taken whenever the result register is empty or is
  // being drained in the same cycle.
  // ---------------------------------------------------------------------------
  logic out_valid_r, out_valid_nxt;
  logic in_fire;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_fire     = in_if.valid && in_if.ready;

  // ---------------------------------------------------------------------------
  // Tracking state for the current region.
  // The pending candidate is the smallest-magnitude sample seen after the
  // current trough; it joins the peak..trough span only if a later sample
  // moves the trough forward.
  // ---------------------------------------------------------------------------
  logic        [TICK_BITS-1:0]   start_tick_r,  start_tick_nxt;
  logic signed [SAMPLE_BITS-1:0] max_value_r,   max_value_nxt;
  logic        [TICK_BITS-1:0]   max_tick_r,    max_tick_nxt;
  logic signed [SAMPLE_BITS-1:0] min_value_r,   min_value_nxt;
  logic        [TICK_BITS-1:0]   min_tick_r,    min_tick_nxt;
  logic        [SAMPLE_BITS-1:0] nz_mag_r,      nz_mag_nxt;
  logic        [TICK_BITS-1:0]   nz_tick_r,     nz_tick_nxt;
  logic        [TICK_BITS-1:0]   pend_tick_r,   pend_tick_nxt;
  logic        [SAMPLE_BITS-1:0] pend_mag_r,    pend_mag_nxt;
  logic                          pend_valid_r,  pend_valid_nxt;

  logic signed [SAMPLE_BITS-1:0] smp;
  logic        [TICK_BITS-1:0]   tck;
  logic        [SAMPLE_BITS-1:0] mag;
  logic        [SAMPLE_BITS-1:0] nz_mag_mid;
  logic        [TICK_BITS-1:0]   nz_tick_mid;

  assign smp = in_if.sample_value;
  assign tck = in_if.tick;
  // Magnitude of the most negative code still fits as an unsigned value
  assign mag = smp[SAMPLE_BITS-1] ? (~smp + 1'b1) : smp;

  always_comb begin
    start_tick_nxt = start_tick_r;
    max_value_nxt  = max_value_r;
    max_tick_nxt   = max_tick_r;
    min_value_nxt  = min_value_r;
    min_tick_nxt   = min_tick_r;
    nz_mag_nxt     = nz_mag_r;
    nz_tick_nxt    = nz_tick_r;
    pend_tick_nxt  = pend_tick_r;
    pend_mag_nxt   = pend_mag_r;
    pend_valid_nxt = pend_valid_r;
    nz_mag_mid     = nz_mag_r;
    nz_tick_mid    = nz_tick_r;

    if (in_if.first_in_roi || smp > max_value_r) begin
      // New region or new maximum: restart peak, trough and crossing here
      if (in_if.first_in_roi) begin
        start_tick_nxt = tck;
      end
      max_value_nxt  = smp;
      max_tick_nxt   = tck;
      min_value_nxt  = smp;
      min_tick_nxt   = tck;
      nz_mag_nxt     = mag;
      nz_tick_nxt    = tck;
      pend_tick_nxt  = '0;
      pend_mag_nxt   = '0;
      pend_valid_nxt = 1'b0;
    end else if (smp < min_value_r) begin
      // Trough moves forward: fold in the pending candidate, then this sample
      min_value_nxt = smp;
      min_tick_nxt  = tck;
      if (pend_valid_r && pend_mag_r < nz_mag_r) begin
        nz_mag_mid  = pend_mag_r;
        nz_tick_mid = pend_tick_r;
      end
      if (mag < nz_mag_mid) begin
        nz_mag_nxt  = mag;
        nz_tick_nxt = tck;
      end else begin
        nz_mag_nxt  = nz_mag_mid;
        nz_tick_nxt = nz_tick_mid;
      end
      pend_tick_nxt  = '0;
      pend_mag_nxt   = '0;
      pend_valid_nxt = 1'b0;
    end else if (!pend_valid_r || mag < pend_mag_r) begin
      pend_valid_nxt = 1'b1;
      pend_mag_nxt   = mag;
      pend_tick_nxt  = tck;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_tick_r <= '0;
      max_value_r  <= '0;
      max_tick_r   <= '0;
      min_value_r  <= '0;
      min_tick_r   <= '0;
      nz_mag_r     <= '0;
      nz_tick_r    <= '0;
      pend_tick_r  <= '0;
      pend_mag_r   <= '0;
      pend_valid_r <= 1'b0;
    end else if (in_fire) begin
      start_tick_r <= start_tick_nxt;
      max_value_r  <= max_value_nxt;
      max_tick_r   <= max_tick_nxt;
      min_value_r  <= min_value_nxt;
      min_tick_r   <= min_tick_nxt;
      nz_mag_r     <= nz_mag_nxt;
      nz_tick_r    <= nz_tick_nxt;
      pend_tick_r  <= pend_tick_nxt;
      pend_mag_r   <= pend_mag_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Region summary and crop window, built from the updated state on the last
  // sample of a region.
  // ---------------------------------------------------------------------------
  logic [TICK_BITS-1:0] anchor;
  logic                 crop;
  logic                 ok;
  logic [CW-1:0]        anchor_w;
  logic [CW-1:0]        pre_w;
  logic [SW-1:0]        end_sum;
  logic [TICK_BITS:0]   roi_end_nxt;
  logic [TICK_BITS-1:0] win_begin_nxt;
  logic [TICK_BITS:0]   win_end_nxt;

  always_comb begin
    anchor = '0;
    crop   = 1'b0;
    ok     = 1'b1;
    case (align_mode_r)
      MODE_PEAK: begin
        anchor = max_tick_nxt;
        crop   = 1'b1;
      end
      MODE_ZERO: begin
        // A crossing on the peak or on the trough is no crossing at all
        if (nz_tick_nxt == max_tick_nxt || nz_tick_nxt == min_tick_nxt) begin
          ok = 1'b0;
        end else begin
          anchor = nz_tick_nxt;
          crop   = 1'b1;
        end
      end
      default: ;  // no crop
    endcase
  end

  assign roi_end_nxt = {1'b0, tck} + 1'b1;
  assign anchor_w    = CW'(anchor);
  assign pre_w       = CW'(pre_samples_r);

  always_comb begin
    if (!crop) begin
      win_begin_nxt = start_tick_nxt;
      end_sum       = SW'(roi_end_nxt);
    end else begin
      // Floor the window start at tick zero
      if (anchor_w < pre_w) begin
        win_begin_nxt = '0;
      end else begin
        win_begin_nxt = TICK_BITS'(anchor_w - pre_w);
      end
      end_sum = SW'(win_begin_nxt) + SW'(total_samples_r);
    end
  end

  assign win_end_nxt = end_sum[TICK_BITS:0];

  // ---------------------------------------------------------------------------
  // Result register. Load on the last sample; hold until the sink takes it.
  // ---------------------------------------------------------------------------
  logic [TICK_BITS-1:0] roi_begin_r;
  logic [TICK_BITS:0]   roi_end_r;
  logic [TICK_BITS-1:0] peak_tick_r;
  logic [TICK_BITS-1:0] trough_tick_r;
  logic [TICK_BITS-1:0] zc_tick_r;
  logic                 align_ok_r;
  logic [TICK_BITS-1:0] win_begin_r;
  logic [TICK_BITS:0]   win_end_r;
  logic                 load_result;

  assign load_result = in_fire && in_if.last_in_roi;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_result) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      roi_begin_r   <= start_tick_nxt;
      roi_end_r     <= roi_end_nxt;
      peak_tick_r   <= max_tick_nxt;
      trough_tick_r <= min_tick_nxt;
      zc_tick_r     <= nz_tick_nxt;
      align_ok_r    <= ok;
      win_begin_r   <= win_begin_nxt;
      win_end_r     <= win_end_nxt;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.roi_begin       = roi_begin_r;
  assign out_if.roi_end         = roi_end_r;
  assign out_if.peak_tick       = peak_tick_r;
  assign out_if.trough_tick     = trough_tick_r;
  assign out_if.zero_cross_tick = zc_tick_r;
  assign out_if.align_ok        = align_ok_r;
  assign out_if.window_begin    = win_begin_r;
  assign out_if.window_end      = win_end_r;

endmodule
`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for the bipolar pulse peak, trough and zero-crossing finder.
`timescale 1ns / 1ps
module tb;
  import pptzc_pkg::*;

  localparam int TB = TICK_BITS_DEF;
  localparam int SB = SAMPLE_BITS_DEF;
  localparam int ITEM_GOAL = 700;

  // Codes the package leaves unnamed: the spare mode acts as no crop,
  // the spare register index is ignored by the block.
  localparam logic [MODE_BITS-1:0]    MODE_SPARE = 2'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [TB-1:0] roi_begin;
    logic [TB:0]   roi_end;
    logic [TB-1:0] peak_tick;
    logic [TB-1:0] trough_tick;
    logic [TB-1:0] zero_cross_tick;
    logic          align_ok;
    logic [TB-1:0] window_begin;
    logic [TB:0]   window_end;
  } roi_summary_t;

  logic clk = 1'b0;
  logic rst_n;

  always #5 clk = ~clk;

  pptzc_in_if  #(.TICK_BITS(TB), .SAMPLE_BITS(SB)) in_if ();
  pptzc_out_if #(.TICK_BITS(TB))                   out_if ();
  pptzc_cfg_if                                     cfg_if ();

  pulse_peak_trough_zero_crossing #(
    .TICK_BITS   (TB),
    .SAMPLE_BITS (SB)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // ---------------------------------------------------------------------------
  // Region tracker: our own copy of the registers and of the running peak,
  // trough and near-zero search. Updated at each accepted transaction.
  // ---------------------------------------------------------------------------
  logic [MODE_BITS-1:0]   align_sel;
  logic [PRE_BITS-1:0]    pre_ticks;
  logic [TOTAL_BITS-1:0]  window_len;

  logic [TB-1:0]          roi_start;
  logic signed [SB-1:0]   peak_val;
  logic [TB-1:0]          peak_at_tick;
  logic signed [SB-1:0]   trough_val;
  logic [TB-1:0]          trough_at_tick;
  logic [SB:0]            zc_mag;
  logic [TB-1:0]          zc_at_tick;
  // best near-zero sample seen since the trough last moved
  logic [SB:0]            cand_mag;
  logic [TB-1:0]          cand_at_tick;
  logic                   cand_valid;

  roi_summary_t roi_summary_q[$];

  int fault_count = 0;
  int samples_sent = 0;
  int summaries_checked = 0;
  int reg_writes = 0;
  int crossing_failures = 0;
  int floored_windows = 0;

  // Shared knobs for the traffic processes.
  bit no_idle = 1'b0;
  int rx_hold_cycles = 0;

  function automatic logic [SB:0] magnitude_of(logic signed [SB-1:0] s);
    logic signed [SB:0] w;
    w = s;
    return (w < 0) ? -w : w;
  endfunction

  function automatic void restart_track(logic signed [SB-1:0] s, logic [TB-1:0] t);
    peak_val       = s;
    peak_at_tick   = t;
    trough_val     = s;
    trough_at_tick = t;
    zc_mag         = magnitude_of(s);
    zc_at_tick     = t;
    cand_mag       = '0;
    cand_at_tick   = '0;
    cand_valid     = 1'b0;
  endfunction

  function automatic void reset_tracker();
    align_sel  = ALIGN_MODE_RST;
    pre_ticks  = PRE_SAMPLES_RST;
    window_len = TOTAL_SAMPLES_RST;
    roi_start  = '0;
    restart_track('0, '0);
  endfunction

  // Advance the tracker by one sample; on the last sample of a region,
  // queue the summary the block must produce.
  function automatic void follow_sample(logic signed [SB-1:0] s, logic [TB-1:0] t,
                                        logic first, logic last);
    logic [SB:0]   mag;
    logic [TB-1:0] anchor;
    logic          crop;
    roi_summary_t  sum;
    mag = magnitude_of(s);
    if (first) begin
      roi_start = t;
      restart_track(s, t);
    end else if (s > peak_val) begin
      restart_track(s, t);
    end else if (s < trough_val) begin
      // the trough moves on, so the held candidate now lies inside peak..trough
      trough_val     = s;
      trough_at_tick = t;
      if (cand_valid && cand_mag < zc_mag) begin
        zc_mag     = cand_mag;
        zc_at_tick = cand_at_tick;
      end
      if (mag < zc_mag) begin
        zc_mag     = mag;
        zc_at_tick = t;
      end
      cand_valid   = 1'b0;
      cand_mag     = '0;
      cand_at_tick = '0;
    end else if (!cand_valid || mag < cand_mag) begin
      cand_valid   = 1'b1;
      cand_mag     = mag;
      cand_at_tick = t;
    end

    if (!last) return;

    sum.roi_begin       = roi_start;
    sum.roi_end         = {1'b0, t} + 1'b1;
    sum.peak_tick       = peak_at_tick;
    sum.trough_tick     = trough_at_tick;
    sum.zero_cross_tick = zc_at_tick;
    sum.align_ok        = 1'b1;
    sum.window_begin    = roi_start;
    sum.window_end      = sum.roi_end;
    anchor = '0;
    crop   = 1'b0;
    if (align_sel == MODE_PEAK) begin
      anchor = peak_at_tick;
      crop   = 1'b1;
    end else if (align_sel == MODE_ZERO) begin
      if (zc_at_tick == peak_at_tick || zc_at_tick == trough_at_tick) begin
        sum.align_ok = 1'b0;
        crossing_failures++;
      end else begin
        anchor = zc_at_tick;
        crop   = 1'b1;
      end
    end
    if (crop) begin
      if (anchor < pre_ticks) floored_windows++;
      sum.window_begin = (anchor < pre_ticks) ? '0 : anchor - pre_ticks;
      sum.window_end   = {1'b0, sum.window_begin} + window_len;
    end
    roi_summary_q = {roi_summary_q, sum};
  endfunction

  function automatic void compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      fault_count++;
    end
  endfunction

  function automatic void check_summary();
    roi_summary_t exp_s;
    if (roi_summary_q.size() == 0) begin
      $display("%0t ns: result with no region pending, expected none, actual roi_begin %0d",
               $time, out_if.roi_begin);
      fault_count++;
      return;
    end
    exp_s = roi_summary_q.pop_front();
    summaries_checked++;
    compare_field("roi_begin",       exp_s.roi_begin,       out_if.roi_begin);
    compare_field("roi_end",         exp_s.roi_end,         out_if.roi_end);
    compare_field("peak_tick",       exp_s.peak_tick,       out_if.peak_tick);
    compare_field("trough_tick",     exp_s.trough_tick,     out_if.trough_tick);
    compare_field("zero_cross_tick", exp_s.zero_cross_tick, out_if.zero_cross_tick);
    compare_field("align_ok",        exp_s.align_ok,        out_if.align_ok);
    compare_field("window_begin",    exp_s.window_begin,    out_if.window_begin);
    compare_field("window_end",      exp_s.window_end,      out_if.window_end);
  endfunction

  // Single observer of all three channels. Register writes and samples are
  // folded into the tracker before the result of the same edge is checked,
  // so the outcome does not hang on process ordering.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) begin
        reg_writes++;
        case (cfg_if.reg_index)
          REG_ALIGN_MODE:    align_sel  = cfg_if.wdata[MODE_BITS-1:0];
          REG_PRE_SAMPLES:   pre_ticks  = cfg_if.wdata[PRE_BITS-1:0];
          REG_TOTAL_SAMPLES: window_len = cfg_if.wdata[TOTAL_BITS-1:0];
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready)
        follow_sample(in_if.sample_value, in_if.tick, in_if.first_in_roi, in_if.last_in_roi);
      if (out_if.valid && out_if.ready)
        check_summary();
    end
  end

  // Result receiver: random stall per transaction, plus a long hold-off on request.
  initial begin : result_sink
    int stall;
    forever begin
      if (rx_hold_cycles > 0) begin
        out_if.ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
    end
  end

  // ---------------------------------------------------------------------------
  // Sample and register drivers
  // ---------------------------------------------------------------------------

  // Offer one sample after a random gap and hold it until accepted.
  // Valid stays high on return so back-to-back samples need no extra edge.
  task automatic send_sample(logic signed [SB-1:0] s, logic [TB-1:0] t, logic first,
                             logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.sample_value <= s;
    in_if.tick         <= t;
    in_if.first_in_roi <= first;
    in_if.last_in_roi  <= last;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    samples_sent++;
  endtask

  // Drop valid, let the observer fold in the last accepted sample, and wait
  // until every queued summary has come back; then allow for a region still
  // in flight that produces nothing.
  task automatic wait_results_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (roi_summary_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wdata     <= data;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
  endtask

  // Rewrite all registers once the block is idle.
  task automatic reconfigure(logic [CFG_DATA_BITS-1:0] mode_w, logic [CFG_DATA_BITS-1:0] pre_w,
                             logic [CFG_DATA_BITS-1:0] total_w, bit poke_unused = 1'b0);
    wait_results_drained();
    write_reg(REG_ALIGN_MODE, mode_w);
    write_reg(REG_PRE_SAMPLES, pre_w);
    write_reg(REG_TOTAL_SAMPLES, total_w);
    if (poke_unused) write_reg(REG_UNUSED, '1);
    cfg_if.valid <= 1'b0;
  endtask

  // Pulse height or dip depth: tiny values give plenty of ties, the top
  // reaches the rails of the sample field.
  function automatic int draw_level();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 15);
      1:       return $urandom_range(16, 1000);
      2:       return $urandom_range(1000, 32767);
      default: return 32768;
    endcase
  endfunction

  // One bipolar pulse: ramp up to the peak, down through zero to the dip,
  // then back toward the baseline. A broken pulse flips flags and scrambles
  // ticks now and then.
  task automatic send_pulse(int len, int amp, int dip, int jitter, bit broken);
    int peak_at, trough_at, i, v;
    logic [TB-1:0] t0, t;
    logic f, l;
    peak_at   = $urandom_range(0, len / 2);
    trough_at = $urandom_range(peak_at, len - 1);
    t0        = $urandom_range(0, (1 << TB) - 1);
    for (i = 0; i < len; i++) begin
      if (i <= peak_at)
        v = (peak_at == 0) ? amp : amp * i / peak_at;
      else if (i <= trough_at)
        v = amp - (amp + dip) * (i - peak_at) / (trough_at - peak_at);
      else
        v = -dip + dip * (i - trough_at) / (len - trough_at);
      if (jitter > 0) v = v + int'($urandom_range(0, 2 * jitter)) - jitter;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      t = t0 + i;
      f = (i == 0);
      l = (i == len - 1);
      if (broken) begin
        if ($urandom_range(0, 7) == 0) f = ~f;
        if ($urandom_range(0, 7) == 0) l = ~l;
        if ($urandom_range(0, 7) == 0) t = $urandom_range(0, (1 << TB) - 1);
      end
      send_sample(v[SB-1:0], t, f, l);
    end
  endtask

  task automatic send_random_region(bit broken);
    int len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
    send_pulse(len, draw_level(), draw_level(), $urandom_range(0, 3), broken);
  endtask

  // Unstructured samples: any value, any tick, flags at random.
  task automatic send_noise(int n);
    repeat (n)
      send_sample($urandom_range(0, 65535), $urandom_range(0, (1 << TB) - 1),
                  $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
  endtask

  function automatic logic [CFG_DATA_BITS-1:0] pick_extreme(int hi);
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return hi;
      default: return $urandom_range(0, hi);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Right after reset: a sample with no first flag continues the all-zero
  // region at tick 0, and the reset register values decide the window.
  task automatic test_reset_state();
    send_sample(-5, 7, 1'b0, 1'b0);
    send_sample(3, 8, 1'b0, 1'b1);
  endtask

  task automatic test_directed_cases();
    // one-sample regions at the rails of value and tick
    send_sample(16'sh7FFF, '1, 1'b1, 1'b1);
    send_sample(16'sh8000, '0, 1'b1, 1'b1);
    // equal peaks, equal troughs, equal magnitudes: the earliest wins
    send_sample(0, 100, 1'b1, 1'b0);
    send_sample(10, 101, 1'b0, 1'b0);
    send_sample(10, 102, 1'b0, 1'b0);
    send_sample(-10, 103, 1'b0, 1'b0);
    send_sample(-10, 104, 1'b0, 1'b1);

    reconfigure(MODE_ZERO, 1023, 1024);
    // crossing lands on the peak: flagged, no crop
    send_sample(100, 50, 1'b1, 1'b0);
    send_sample(-100, 51, 1'b0, 1'b1);
    // crossing lands on the trough
    send_sample(100, 10, 1'b1, 1'b0);
    send_sample(-1, 11, 1'b0, 1'b1);
    // clean crossing between the two
    send_sample(50, 3000, 1'b1, 1'b0);
    send_sample(2, 3001, 1'b0, 1'b0);
    send_sample(-40, 3002, 1'b0, 1'b1);
    // held candidate gets pulled in when the trough moves; window floors at 0
    send_sample(50, 20, 1'b1, 1'b0);
    send_sample(-30, 21, 1'b0, 1'b0);
    send_sample(-5, 22, 1'b0, 1'b0);
    send_sample(-60, 23, 1'b0, 1'b1);

    // spare mode means no crop, so the zero total_samples has no effect; ignored register index
    reconfigure(MODE_SPARE, 7, 0, 1'b1);
    send_sample(5, 8000, 1'b1, 1'b0);
    send_sample(-7, 12, 1'b0, 1'b0);
    send_sample(9, 4000, 0, 1'b1);

    // widest window from the top tick
    reconfigure(MODE_PEAK, 0, 2047);
    send_sample(1, 8190, 1'b1, 1'b0);
    send_sample(2, 8191, 1'b0, 1'b1);
  endtask

  task automatic test_config_sweep();
    int step;
    for (step = 0; step < 6; step++) begin
      case (step)
        0: reconfigure(MODE_NONE, 0, 1);
        1: reconfigure(MODE_PEAK, 1023, 0);
        2: reconfigure(MODE_PEAK, 0, 1);
        3: reconfigure(MODE_ZERO, 0, 2047);
        4: reconfigure(MODE_PEAK, 1023, 1024);
        default: reconfigure(MODE_ZERO, $urandom_range(0, 1023), $urandom_range(1, 1024));
      endcase
      repeat (3) send_random_region(1'b0);
    end
  endtask

  // Mostly clean pulses with random content, some broken ones and noise;
  // new registers and a new idling style every dozen regions.
  task automatic test_random_traffic();
    int regions, pick;
    regions = 0;
    while (samples_sent < ITEM_GOAL - 100) begin
      if (regions % 12 == 0) begin
        reconfigure($urandom_range(0, 3), pick_extreme(1023), pick_extreme(2047));
        no_idle = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 9);
      if (pick < 7)
        send_random_region(1'b0);
      else if (pick < 9)
        send_random_region(1'b1);
      else
        send_noise($urandom_range(1, 6));
      regions++;
    end
    no_idle = 1'b0;
  endtask

  // Hold the receiver off for a long stretch while short regions keep
  // coming, so results pile up and the sample input stalls.
  task automatic test_backpressure();
    reconfigure(MODE_PEAK, $urandom_range(0, 1023), $urandom_range(1, 1024));
    no_idle = 1'b1;
    rx_hold_cycles = 200;
    repeat (25) send_pulse($urandom_range(1, 3), draw_level(), draw_level(), 0, 1'b0);
    no_idle = 1'b0;
    wait_results_drained();
  endtask

  // Sender stops until every summary is back, then resumes mid-mode.
  task automatic test_sender_pause();
    reconfigure(MODE_ZERO, $urandom_range(0, 1023), $urandom_range(1, 1024));
    repeat (3) send_random_region(1'b0);
    wait_results_drained();
    repeat (3) send_random_region(1'b0);
  endtask

  initial begin : run_all
    int tail;
    rst_n            <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.sample_value <= '0;
    in_if.tick       <= '0;
    in_if.first_in_roi <= 1'b0;
    in_if.last_in_roi  <= 1'b0;
    cfg_if.valid     <= 1'b0;
    cfg_if.reg_index <= REG_ALIGN_MODE;
    cfg_if.wdata     <= '0;
    reset_tracker();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_directed_cases();
    test_config_sweep();
    test_random_traffic();
    test_backpressure();
    test_sender_pause();

    // Drain with a bound, then let any stray result surface.
    in_if.valid <= 1'b0;
    tail = 0;
    while (roi_summary_q.size() != 0 && tail < 2000) begin
      @(posedge clk);
      tail++;
    end
    repeat (8) @(posedge clk);
    if (roi_summary_q.size() != 0) begin
      $display("%0t ns: regions left without a result, expected 0, actual %0d",
               $time, roi_summary_q.size());
      fault_count++;
    end

    $display("Covered %0d samples and %0d region summaries over %0d register writes.",
             samples_sent, summaries_checked, reg_writes);
    $display("Failed crossings: %0d, windows clipped at tick zero: %0d, field faults: %0d.",
             crossing_failures, floored_windows, fault_count);
    if (fault_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #(3_000_000);
    $display("FAIL");
    $finish;
  end

endmodule
